### rtl/core/lep_pkg.sv
// Shared constants, types and register map of the Lorenz particle stepper.
package lep_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int RAM_AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  localparam int POS_W = 32;
  localparam int COEF_W = 23;
  localparam int DT_W = 24;
  localparam int CNT_CFG_W = 7;

  // Shared multiplier: signed 33 x 33 -> 66
  localparam int MUL_W = POS_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  localparam int FRAC_SH = 16;
  localparam int DERIV_W = 48;
  localparam int DT_SPLIT = 25;
  localparam int DT_SH = 24;
  localparam int DT_HI_W = DERIV_W - DT_SPLIT;
  localparam int DT_LO_P_W = DT_SPLIT + DT_W;
  localparam int DT_HI_P_W = DT_HI_W + DT_W;
  localparam int ACC_W = DT_HI_P_W + DT_SPLIT;
  localparam int SUM_W = DERIV_W + 1;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_SIGMA = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RHO = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BETA = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE = 3'd4;

  localparam logic [COEF_W-1:0] SIGMA_RST = 23'd655360;
  localparam logic [COEF_W-1:0] RHO_RST = 23'd1835008;
  localparam logic [COEF_W-1:0] BETA_RST = 23'd174763;
  localparam logic [DT_W-1:0] STEP_RST = 24'd16777;
  localparam logic [CNT_CFG_W-1:0] ACTIVE_RST = 7'd20;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef logic signed [POS_W-1:0] coord_t;
  typedef logic signed [MUL_W-1:0] mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pos_t;

  typedef struct packed {
    logic esc;
    pos_t pos;
  } slot_t;

  typedef struct packed {
    logic [COEF_W-1:0] sigma;
    logic [COEF_W-1:0] rho;
    logic [COEF_W-1:0] beta;
    logic [DT_W-1:0]   dt;
  } coef_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } step_sts_t;

endpackage

### rtl/core/lep_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lep_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/lep_mul.sv
// Shared signed multiplier with a registered product.
module lep_mul (
  input  logic            clk,
  input  lep_pkg::mul_op_t a,
  input  lep_pkg::mul_op_t b,
  output lep_pkg::prod_t   p
);

  lep_pkg::prod_t p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

### rtl/core/lep_step.sv
// Sequencer that advances one particle by one Euler step on the shared multiplier.
module lep_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lep_pkg::pos_t      pos_in,
  input  lep_pkg::coef_t     coef,
  output lep_pkg::pos_t      pos_out,
  output lep_pkg::step_sts_t sts
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DA   = 8'b0000_0010,
    ST_DB   = 8'b0000_0100,
    ST_DC   = 8'b0000_1000,
    ST_SL   = 8'b0001_0000,
    ST_SH   = 8'b0010_0000,
    ST_SA   = 8'b0100_0000,
    ST_SUM  = 8'b1000_0000
  } step_state_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  localparam lep_pkg::coord_t POS_MAX = {1'b0, {(lep_pkg::POS_W-1){1'b1}}};
  localparam lep_pkg::coord_t POS_MIN = {1'b1, {(lep_pkg::POS_W-1){1'b0}}};

  step_state_t state_r, state_nxt;
  axis_t       axis_r, axis_nxt;
  lep_pkg::pos_t cur_r, cur_nxt;
  lep_pkg::pos_t res_r, res_nxt;
  logic signed [lep_pkg::DERIV_W-1:0] d_r, d_nxt;
  logic signed [lep_pkg::DERIV_W-1:0] t_r, t_nxt;
  logic signed [lep_pkg::DERIV_W-1:0] step_r, step_nxt;
  logic [lep_pkg::DT_LO_P_W-1:0] lo_r, lo_nxt;
  logic ovf_r, ovf_nxt;
  logic done_r, done_nxt;

  lep_pkg::mul_op_t mul_a, mul_b;
  lep_pkg::prod_t   prod;
  logic signed [lep_pkg::DERIV_W-1:0] prod_sh;
  logic signed [lep_pkg::ACC_W-1:0]   acc;
  lep_pkg::coord_t base;
  logic signed [lep_pkg::SUM_W-1:0]   sum;
  logic [lep_pkg::SUM_W-lep_pkg::POS_W:0] sum_hi;
  lep_pkg::coord_t sat;
  logic sat_ovf;

  function automatic lep_pkg::mul_op_t sx_pos(lep_pkg::coord_t v);
    return {{(lep_pkg::MUL_W-lep_pkg::POS_W){v[lep_pkg::POS_W-1]}}, v};
  endfunction

  function automatic lep_pkg::mul_op_t zx_coef(logic [lep_pkg::COEF_W-1:0] v);
    return {{(lep_pkg::MUL_W-lep_pkg::COEF_W){1'b0}}, v};
  endfunction

  lep_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Q16.16 product back to Q16.16, floor
  assign prod_sh = $signed(prod[lep_pkg::FRAC_SH +: lep_pkg::DERIV_W]);

  // Recombine the two partial products of deriv * dt
  assign acc = $signed({prod[lep_pkg::DT_HI_P_W-1:0], {lep_pkg::DT_SPLIT{1'b0}}})
             + $signed({{(lep_pkg::ACC_W-lep_pkg::DT_LO_P_W){1'b0}}, lo_r});

  always_comb begin
    case (axis_r)
      AX_X:    base = cur_r.x;
      AX_Y:    base = cur_r.y;
      default: base = cur_r.z;
    endcase
  end

  // sign-extend both terms explicitly so a negative step stays negative
  assign sum = {{(lep_pkg::SUM_W-lep_pkg::POS_W){base[lep_pkg::POS_W-1]}}, base}
             + {{(lep_pkg::SUM_W-lep_pkg::DERIV_W){step_r[lep_pkg::DERIV_W-1]}}, step_r};
  assign sum_hi = sum[lep_pkg::SUM_W-1:lep_pkg::POS_W-1];

  always_comb begin
    sat_ovf = 1'b0;
    sat = sum[lep_pkg::POS_W-1:0];
    if (!((&sum_hi) || !(|sum_hi))) begin
      sat_ovf = 1'b1;
      sat = sum[lep_pkg::SUM_W-1] ? POS_MIN : POS_MAX;
    end
  end

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_DA: begin
        case (axis_r)
          AX_X: begin
            mul_a = zx_coef(coef.sigma);
            mul_b = sx_pos(cur_r.y) - sx_pos(cur_r.x);
          end
          AX_Y: begin
            mul_a = sx_pos(cur_r.x);
            mul_b = zx_coef(coef.rho) - sx_pos(cur_r.z);
          end
          default: begin
            mul_a = sx_pos(cur_r.x);
            mul_b = sx_pos(cur_r.y);
          end
        endcase
      end
      ST_DB: begin
        mul_a = zx_coef(coef.beta);
        mul_b = sx_pos(cur_r.z);
      end
      ST_SL: begin
        mul_a = {{(lep_pkg::MUL_W-lep_pkg::DT_SPLIT){1'b0}}, d_r[lep_pkg::DT_SPLIT-1:0]};
        mul_b = {{(lep_pkg::MUL_W-lep_pkg::DT_W){1'b0}}, coef.dt};
      end
      ST_SH: begin
        mul_a = {{(lep_pkg::MUL_W-lep_pkg::DT_HI_W){d_r[lep_pkg::DERIV_W-1]}},
                 d_r[lep_pkg::DERIV_W-1:lep_pkg::DT_SPLIT]};
        mul_b = {{(lep_pkg::MUL_W-lep_pkg::DT_W){1'b0}}, coef.dt};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cur_nxt   = cur_r;
    res_nxt   = res_r;
    d_nxt     = d_r;
    t_nxt     = t_r;
    step_nxt  = step_r;
    lo_nxt    = lo_r;
    ovf_nxt   = ovf_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cur_nxt   = pos_in;
          axis_nxt  = AX_X;
          ovf_nxt   = 1'b0;
          state_nxt = ST_DA;
        end
      end
      ST_DA: state_nxt = ST_DB;
      ST_DB: begin
        case (axis_r)
          AX_X: begin
            d_nxt     = prod_sh;
            state_nxt = ST_SL;
          end
          AX_Y: begin
            d_nxt = prod_sh
                  - {{(lep_pkg::DERIV_W-lep_pkg::POS_W){cur_r.y[lep_pkg::POS_W-1]}}, cur_r.y};
            state_nxt = ST_SL;
          end
          default: begin
            // hold x*y while beta*z goes through the multiplier
            t_nxt     = prod_sh;
            state_nxt = ST_DC;
          end
        endcase
      end
      ST_DC: begin
        d_nxt     = t_r - prod_sh;
        state_nxt = ST_SL;
      end
      ST_SL: state_nxt = ST_SH;
      ST_SH: begin
        lo_nxt    = prod[lep_pkg::DT_LO_P_W-1:0];
        state_nxt = ST_SA;
      end
      ST_SA: begin
        step_nxt  = acc[lep_pkg::ACC_W-1:lep_pkg::DT_SH];
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        ovf_nxt = ovf_r | sat_ovf;
        case (axis_r)
          AX_X: begin
            res_nxt.x = sat;
            axis_nxt  = AX_Y;
            state_nxt = ST_DA;
          end
          AX_Y: begin
            res_nxt.y = sat;
            axis_nxt  = AX_Z;
            state_nxt = ST_DA;
          end
          default: begin
            res_nxt.z = sat;
            done_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= AX_X;
      ovf_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      ovf_r   <= ovf_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    res_r  <= res_nxt;
    d_r    <= d_nxt;
    t_r    <= t_nxt;
    step_r <= step_nxt;
    lo_r   <= lo_nxt;
  end

  assign pos_out = res_r;
  assign sts = '{done: done_r, ovf: ovf_r};

endmodule

### rtl/core/lorenz_euler_particle_stepper_unit.sv
// Top level of the Lorenz particle stepper: config port, request channel, table, result channel.
//
// The block keeps up to 64 particle positions (x, y, z, signed Q16.16) plus a
// sticky escape flag per particle in one on-chip RAM. A load word (req_type 0)
// writes one slot, clears its escape flag and returns no
// result. A tick word (req_type 1) walks slots 0 .. n-1, n being active_particles
// capped at 64, and sends one result word per slot in index order with
// last_of_tick on the final one; n of zero returns nothing. Each non-escaped
// particle goes through one RAM read, one fetch, then the step
// sequencer, whose single 33x33 multiplier fires four times per axis (the
// derivative product, beta*z, which only the z derivative keeps, and a low and
// a high partial product of derivative times dt) and whose
// add/saturate ends each axis, then a collect step and a hand-over of the
// word to the output register. An escaped particle is frozen and skips the
// step sequencer. The hand-over waits while the result side
// holds out_stall.
// in_stall stays high from an accepted tick until its last word sits in the
// output register, so a new request is taken while that word still waits.
// After reset every slot reads as zero through per-slot valid bits, with no
// clearing pass. Coordinates that leave the 32-bit range saturate and set the
// escape flag. Registers sit on the APB-style port at byte addresses 0, 4,
// 8, 12, 16 (sigma, rho, beta, dt, active count) and read back the bits they keep.
module lorenz_euler_particle_stepper_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [lep_pkg::IDX_W-1:0]           in_load_index,
  input  logic signed [lep_pkg::POS_W-1:0]    in_load_x,
  input  logic signed [lep_pkg::POS_W-1:0]    in_load_y,
  input  logic signed [lep_pkg::POS_W-1:0]    in_load_z,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lep_pkg::IDX_W-1:0]           out_particle_id,
  output logic signed [lep_pkg::POS_W-1:0]    out_new_x,
  output logic signed [lep_pkg::POS_W-1:0]    out_new_y,
  output logic signed [lep_pkg::POS_W-1:0]    out_new_z,
  output logic                                out_escaped,
  output logic                                out_last_of_tick,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lep_pkg::ADDR_W-1:0]          paddr,
  input  logic [lep_pkg::DATA_W-1:0]          pwdata,
  output logic [lep_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_READ  = 5'b00010,
    T_FETCH = 5'b00100,
    T_CALC  = 5'b01000,
    T_EMIT  = 5'b10000
  } tick_state_t;

  localparam logic [lep_pkg::CNT_W-1:0] MAX_CNT = lep_pkg::CNT_W'(lep_pkg::MAX_PARTICLES);
  localparam int SLOT_W = $bits(lep_pkg::slot_t);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [lep_pkg::COEF_W-1:0]    sigma_r, rho_r, beta_r;
  logic [lep_pkg::DT_W-1:0]      dt_r;
  logic [lep_pkg::CNT_CFG_W-1:0] active_r;
  logic [lep_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lep_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r  <= lep_pkg::SIGMA_RST;
      rho_r    <= lep_pkg::RHO_RST;
      beta_r   <= lep_pkg::BETA_RST;
      dt_r     <= lep_pkg::STEP_RST;
      active_r <= lep_pkg::ACTIVE_RST;
    end else if (cfg_wr) begin
      // keep the low bits; drop writes past the register list
      unique case (reg_idx)
        lep_pkg::REG_SIGMA:  sigma_r  <= pwdata[lep_pkg::COEF_W-1:0];
        lep_pkg::REG_RHO:    rho_r    <= pwdata[lep_pkg::COEF_W-1:0];
        lep_pkg::REG_BETA:   beta_r   <= pwdata[lep_pkg::COEF_W-1:0];
        lep_pkg::REG_STEP:   dt_r     <= pwdata[lep_pkg::DT_W-1:0];
        lep_pkg::REG_ACTIVE: active_r <= pwdata[lep_pkg::CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lep_pkg::REG_SIGMA:  prdata = lep_pkg::DATA_W'(sigma_r);
      lep_pkg::REG_RHO:    prdata = lep_pkg::DATA_W'(rho_r);
      lep_pkg::REG_BETA:   prdata = lep_pkg::DATA_W'(beta_r);
      lep_pkg::REG_STEP:   prdata = lep_pkg::DATA_W'(dt_r);
      lep_pkg::REG_ACTIVE: prdata = lep_pkg::DATA_W'(active_r);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tick walker
  // ---------------------------------------------------------------------------
  tick_state_t state_r, state_nxt;
  logic [lep_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [lep_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  lep_pkg::slot_t cur_r, cur_nxt;

  logic in_accept;
  logic load_ok;
  logic load_wr;
  logic emit_wr;
  logic out_free;
  logic last;
  logic [lep_pkg::CNT_W-1:0] n_clamp;

  // table RAM and per-slot valid bits
  logic [lep_pkg::MAX_PARTICLES-1:0] valid_r;
  logic                       vld_q_r;
  logic                       ram_we;
  logic [lep_pkg::RAM_AW-1:0] ram_waddr;
  logic [lep_pkg::RAM_AW-1:0] ram_raddr;
  lep_pkg::slot_t             ram_wword;
  lep_pkg::slot_t             ram_rword;
  logic [SLOT_W-1:0]          ram_rdata;
  lep_pkg::slot_t             slot_cur;

  // step sequencer
  logic                step_start;
  lep_pkg::coef_t      coef;
  lep_pkg::pos_t       step_pos;
  lep_pkg::step_sts_t  step_sts;

  assign in_stall  = ~(state_r == T_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;
  assign n_clamp   = (active_r > MAX_CNT) ? MAX_CNT : active_r;
  assign last      = (lep_pkg::CNT_W'(idx_r) + lep_pkg::CNT_W'(1)) == cnt_r;
  assign load_ok   = lep_pkg::CNT_W'(in_load_index) < MAX_CNT;

  assign load_wr = in_accept & (in_req_type == lep_pkg::REQ_LOAD) & load_ok;
  assign emit_wr = (state_r == T_EMIT) & out_free;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    cur_nxt    = cur_r;
    step_start = 1'b0;
    unique case (state_r)
      T_IDLE: begin
        if (in_accept && (in_req_type == lep_pkg::REQ_TICK) && (n_clamp != '0)) begin
          cnt_nxt   = n_clamp;
          idx_nxt   = '0;
          state_nxt = T_READ;
        end
      end
      T_READ: state_nxt = T_FETCH;
      T_FETCH: begin
        cur_nxt = slot_cur;
        if (slot_cur.esc) begin
          // frozen particle: send it back unchanged
          state_nxt = T_EMIT;
        end else begin
          step_start = 1'b1;
          state_nxt  = T_CALC;
        end
      end
      T_CALC: begin
        if (step_sts.done) begin
          cur_nxt.pos = step_pos;
          cur_nxt.esc = step_sts.ovf;
          state_nxt   = T_EMIT;
        end
      end
      T_EMIT: begin
        if (out_free) begin
          if (last) begin
            state_nxt = T_IDLE;
          end else begin
            idx_nxt   = idx_r + lep_pkg::IDX_W'(1);
            state_nxt = T_READ;
          end
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // ---------------------------------------------------------------------------
  // Particle table
  // ---------------------------------------------------------------------------
  // Load and write-back never overlap: loads land only while the walker idles.
  assign ram_we    = load_wr | emit_wr;
  assign ram_waddr = emit_wr ? idx_r[lep_pkg::RAM_AW-1:0]
                             : in_load_index[lep_pkg::RAM_AW-1:0];
  assign ram_raddr = idx_r[lep_pkg::RAM_AW-1:0];

  always_comb begin
    if (emit_wr) begin
      ram_wword = cur_r;
    end else begin
      ram_wword.esc   = 1'b0;
      ram_wword.pos.x = in_load_x;
      ram_wword.pos.y = in_load_y;
      ram_wword.pos.z = in_load_z;
    end
  end

  lep_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (lep_pkg::MAX_PARTICLES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wword),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_rword = lep_pkg::slot_t'(ram_rdata);

  // Sample the valid bit alongside the RAM read; a never-written slot reads zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
    end else begin
      vld_q_r <= valid_r[ram_raddr];
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  assign slot_cur = vld_q_r ? ram_rword : '0;

  // ---------------------------------------------------------------------------
  // Step sequencer on the shared multiplier
  // ---------------------------------------------------------------------------
  assign coef = '{sigma: sigma_r, rho: rho_r, beta: beta_r, dt: dt_r};

  lep_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (step_start),
    .pos_in  (slot_cur.pos),
    .coef    (coef),
    .pos_out (step_pos),
    .sts     (step_sts)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold a word until taken, advance the walker meanwhile
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic [lep_pkg::IDX_W-1:0] out_id_r;
  lep_pkg::slot_t            out_slot_r;
  logic                      out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_wr) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_wr) begin
      out_id_r   <= idx_r;
      out_slot_r <= cur_r;
      out_last_r <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_particle_id  = out_id_r;
  assign out_new_x        = out_slot_r.pos.x;
  assign out_new_y        = out_slot_r.pos.y;
  assign out_new_z        = out_slot_r.pos.z;
  assign out_escaped      = out_slot_r.esc;
  assign out_last_of_tick = out_last_r;

endmodule
